/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ctp_pkg.sv */
`default_nettype none

package ctp_pkg;

    // Channel interpretation of an incoming pixel
    typedef enum logic
    {
        OP_RGB = 1'b0,
        OP_HSV = 1'b1
    } opcode_t;

    typedef logic [7:0] chan_t;
    typedef logic [2:0] region_t;
    typedef logic [2:0] level_t;
    typedef logic [4:0] grey_t;

    localparam int unsigned SumWidth    = 10;
    localparam int unsigned Sum100Width = 17;

    typedef logic [SumWidth-1:0]    sum_t;
    typedef logic [Sum100Width-1:0] sum100_t;

    typedef struct packed
    {
        opcode_t opcode;
        chan_t   chan_first;
        chan_t   chan_second;
        chan_t   chan_third;
    } pixel_t;

    typedef struct packed
    {
        chan_t palette_index;
        chan_t red_out;
        chan_t green_out;
        chan_t blue_out;
    } result_t;

    typedef struct packed
    {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    localparam chan_t       ChanMax    = 8'hFF;
    localparam int unsigned HueSpan    = 43;
    localparam int unsigned HueRegions = 6;
    localparam int unsigned RemScale   = 6;
    localparam int unsigned LevelFloor = 75;
    localparam int unsigned LevelBias  = 36;
    localparam int unsigned LevelStep  = 40;
    localparam int unsigned LevelMax   = 5;
    localparam int unsigned GreyScale  = 100;
    localparam int unsigned GreyStep   = 2943;
    localparam int unsigned GreyLevels = 25;
    localparam int unsigned CubeBase   = 16;
    localparam int unsigned CubeTop    = 231;
    localparam int unsigned CubeRed    = 36;
    localparam int unsigned CubeGreen  = 6;

    // Hue region 0..5: count the region boundaries at or below the hue
    function automatic region_t hue_region(input chan_t hue);
        region_t rg;
        rg = '0;
        for (int k = 1; k < HueRegions; k++)
        begin
            if (32'(hue) >= HueSpan * k)
                rg = 3'(k);
        end
        return rg;
    endfunction

    // Cube level 0..5 of one channel
    function automatic level_t level6(input chan_t x);
        level_t lv;
        lv = '0;
        if (32'(x) > LevelFloor)
        begin
            lv = 3'd1;
            for (int k = 2; k <= LevelMax; k++)
            begin
                if (32'(x) >= LevelBias + LevelStep * k)
                    lv = 3'(k);
            end
        end
        return lv;
    endfunction

    // Grey level 0..25 from the channel sum scaled by one hundred
    function automatic grey_t grey_level(input sum100_t x);
        grey_t gl;
        gl = '0;
        for (int k = 1; k <= GreyLevels; k++)
        begin
            if (32'(x) >= GreyStep * k)
                gl = 5'(k);
        end
        return gl;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ctp_hsv.sv */
`default_nettype none

// Three-stage HSV to RGB converter; RGB requests pass through unchanged
module ctp_hsv
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pixel_valid,
    output logic                 pixel_stall,
    input  wire ctp_pkg::pixel_t pixel,
    output logic                 rgb_valid,
    input  wire logic            rgb_stall,
    output ctp_pkg::rgb_t        rgb
);

    typedef struct packed
    {
        ctp_pkg::opcode_t opcode;
        ctp_pkg::chan_t   chan_first;
        ctp_pkg::chan_t   chan_second;
        ctp_pkg::chan_t   chan_third;
        ctp_pkg::region_t region;
        ctp_pkg::chan_t   rem;
    } s1_t;

    typedef struct packed
    {
        ctp_pkg::opcode_t opcode;
        ctp_pkg::chan_t   chan_first;
        ctp_pkg::chan_t   chan_second;
        ctp_pkg::chan_t   chan_third;
        ctp_pkg::region_t region;
        ctp_pkg::chan_t   p;
        ctp_pkg::chan_t   sq;
        ctp_pkg::chan_t   st;
    } s2_t;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    ctp_pkg::rgb_t s3_reg, s3_next;

    ctp_pkg::chan_t   base;
    logic [5:0]       offset;
    logic [15:0]      prod_p, prod_sq, prod_st, prod_q, prod_t;
    ctp_pkg::chan_t   q, t;

    // Advance a stage when it is empty or its successor moves
    assign rdy3        = !v3_reg || !rgb_stall;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign pixel_stall = !rdy1;

    // Stage 1: hue region and scaled remainder
    always_comb
    begin
        s1_next.opcode      = pixel.opcode;
        s1_next.chan_first  = pixel.chan_first;
        s1_next.chan_second = pixel.chan_second;
        s1_next.chan_third  = pixel.chan_third;
        s1_next.region      = ctp_pkg::hue_region(pixel.chan_first);
        base                = 8'(ctp_pkg::HueSpan * 32'(s1_next.region));
        offset              = 6'(pixel.chan_first - base);
        s1_next.rem         = 8'(32'(offset) * ctp_pkg::RemScale);
    end

    // Stage 2: p and the saturation products
    always_comb
    begin
        prod_p  = 16'(s1_reg.chan_third) * 16'(ctp_pkg::ChanMax - s1_reg.chan_second);
        prod_sq = 16'(s1_reg.chan_second) * 16'(s1_reg.rem);
        prod_st = 16'(s1_reg.chan_second) * 16'(ctp_pkg::ChanMax - s1_reg.rem);
        s2_next.opcode      = s1_reg.opcode;
        s2_next.chan_first  = s1_reg.chan_first;
        s2_next.chan_second = s1_reg.chan_second;
        s2_next.chan_third  = s1_reg.chan_third;
        s2_next.region      = s1_reg.region;
        s2_next.p           = prod_p[15:8];
        s2_next.sq          = prod_sq[15:8];
        s2_next.st          = prod_st[15:8];
    end

    // Stage 3: q and t, then pick the triple for the region
    always_comb
    begin
        prod_q = 16'(s2_reg.chan_third) * 16'(ctp_pkg::ChanMax - s2_reg.sq);
        prod_t = 16'(s2_reg.chan_third) * 16'(ctp_pkg::ChanMax - s2_reg.st);
        q      = prod_q[15:8];
        t      = prod_t[15:8];
        s3_next = '{s2_reg.chan_first, s2_reg.chan_second, s2_reg.chan_third};
        if (s2_reg.opcode == ctp_pkg::OP_HSV)
        begin
            if (s2_reg.chan_second == '0)
            begin
                s3_next = '{s2_reg.chan_third, s2_reg.chan_third, s2_reg.chan_third};
            end
            else
            begin
                unique case (s2_reg.region)
                    3'd0:    s3_next = '{s2_reg.chan_third, t, s2_reg.p};
                    3'd1:    s3_next = '{q, s2_reg.chan_third, s2_reg.p};
                    3'd2:    s3_next = '{s2_reg.p, s2_reg.chan_third, t};
                    3'd3:    s3_next = '{s2_reg.p, q, s2_reg.chan_third};
                    3'd4:    s3_next = '{t, s2_reg.p, s2_reg.chan_third};
                    default: s3_next = '{s2_reg.chan_third, s2_reg.p, q};
                endcase
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= pixel_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // Payload: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (rdy1 && pixel_valid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
        if (rdy3 && v2_reg)
            s3_reg <= s3_next;
    end

    assign rgb_valid = v3_reg;
    assign rgb       = s3_reg;

endmodule

`default_nettype wire

/* rtl/core/color_to_terminal_palette.sv */
`default_nettype none
`include "assert_macros.svh"

// Converts a stream of pixels, given as RGB or as integer HSV with hue on
// 0..255, to an xterm 256-colour index (cube 16..231, grey ramp 232..255
// with its ends folded to 16 and 231) and returns the RGB triple used.
// One pixel is accepted per clock while pixel_stall is low. A request passes
// through five register stages in order: hue split, two multiplier
// stages, channel levels and sum, then grey compare and index.
// A stall on the result side is absorbed by empty stages before it
// reaches the pixel side.
module color_to_terminal_palette
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pixel_valid,
    output logic                  pixel_stall,
    input  wire ctp_pkg::pixel_t  pixel,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output ctp_pkg::result_t      result
);

    typedef struct packed
    {
        ctp_pkg::rgb_t    px;
        ctp_pkg::level_t  lr;
        ctp_pkg::level_t  lg;
        ctp_pkg::level_t  lb;
        ctp_pkg::sum100_t sum100;
    } s4_t;

    logic             hsv_valid, hsv_stall;
    ctp_pkg::rgb_t    hsv_rgb;
    logic             v4_reg, v5_reg;
    logic             rdy4, rdy5;
    s4_t              s4_reg, s4_next;
    ctp_pkg::result_t s5_reg, s5_next;
    ctp_pkg::sum_t    sum;
    ctp_pkg::grey_t   grey;

    ctp_hsv u_hsv
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .rgb_valid   (hsv_valid),
        .rgb_stall   (hsv_stall),
        .rgb         (hsv_rgb)
    );

    // Advance a stage when it is empty or its successor moves
    assign rdy5      = !v5_reg || !result_stall;
    assign rdy4      = !v4_reg || rdy5;
    assign hsv_stall = !rdy4;

    // Stage 4: cube levels and scaled channel sum
    always_comb
    begin
        sum = ctp_pkg::sum_t'(hsv_rgb.red) + ctp_pkg::sum_t'(hsv_rgb.green)
            + ctp_pkg::sum_t'(hsv_rgb.blue);
        s4_next.px     = hsv_rgb;
        s4_next.lr     = ctp_pkg::level6(hsv_rgb.red);
        s4_next.lg     = ctp_pkg::level6(hsv_rgb.green);
        s4_next.lb     = ctp_pkg::level6(hsv_rgb.blue);
        s4_next.sum100 = ctp_pkg::sum100_t'(sum)
                       * ctp_pkg::sum100_t'(ctp_pkg::GreyScale);
    end

    // Stage 5: grey ramp or cube index
    always_comb
    begin
        grey                = ctp_pkg::grey_level(s4_reg.sum100);
        s5_next.red_out     = s4_reg.px.red;
        s5_next.green_out   = s4_reg.px.green;
        s5_next.blue_out    = s4_reg.px.blue;
        if (s4_reg.lr == s4_reg.lg && s4_reg.lg == s4_reg.lb)
        begin
            priority if (grey == '0)
                s5_next.palette_index = 8'(ctp_pkg::CubeBase);
            else if (32'(grey) == ctp_pkg::GreyLevels)
                s5_next.palette_index = 8'(ctp_pkg::CubeTop);
            else
                s5_next.palette_index = 8'(ctp_pkg::CubeTop + 32'(grey));
        end
        else
        begin
            s5_next.palette_index = 8'(ctp_pkg::CubeBase
                                  + ctp_pkg::CubeRed * 32'(s4_reg.lr)
                                  + ctp_pkg::CubeGreen * 32'(s4_reg.lg)
                                  + 32'(s4_reg.lb));
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                v4_reg <= hsv_valid;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    // Payload: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (rdy4 && hsv_valid)
            s4_reg <= s4_next;
        if (rdy5 && v4_reg)
            s5_reg <= s5_next;
    end

    assign result_valid = v5_reg;
    assign result       = s5_reg;

    // Stage 4 holds its request while the output register is stalled
    `ASSERT_NEXT(a_s4_hold, v4_reg && !rdy4, v4_reg && $stable(s4_reg), "stage 4 lost a request")
    // A request leaving stage 4 lands in the output register
    `ASSERT_NEXT(a_s4_to_out, v4_reg && rdy5, result_valid, "request dropped before output")
    // Every index lies in the cube or on the grey ramp
    `ASSERT_IMPL(a_index_range, result_valid, result.palette_index >= 8'(ctp_pkg::CubeBase), "index below 16")

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ClockPeriod   = 12;
    localparam int unsigned ResetCycles   = 12;
    localparam int unsigned ResultLatency = 5;
    localparam int unsigned RandomPixels  = 1750;
    localparam int unsigned CycleLimit    = 200000;
    localparam int unsigned ReportCap     = 40;

    // Arithmetic of the conversion, kept apart from the design's own constants
    localparam int unsigned SectorSpan = 43;
    localparam int unsigned FracScale  = 6;
    localparam int unsigned FullScale  = 255;
    localparam int unsigned DarkLimit  = 75;
    localparam int unsigned StepBias   = 36;
    localparam int unsigned StepWidth  = 40;
    localparam int unsigned ShadeMul   = 100;
    localparam int unsigned ShadeDiv   = 2943;
    localparam int unsigned ShadeTop   = 25;
    localparam int unsigned IndexBase  = 16;
    localparam int unsigned IndexTop   = 231;

    typedef enum logic [1:0]
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_SQUARE
    } stall_mode_t;

    typedef struct
    {
        ctp_pkg::pixel_t  px;
        bit               typed;
        ctp_pkg::result_t want;
    } stim_row_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             pixel_valid  = 1'b0;
    logic             pixel_stall;
    ctp_pkg::pixel_t  pixel        = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    ctp_pkg::result_t result;

    ctp_pkg::result_t pending_colours[$];
    stim_row_t        directed_rows[$];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count    = 0;
    int unsigned      burst_left     = 0;

    color_to_terminal_palette dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #(ClockPeriod / 2) clk = ~clk;

    // Six-sector integer HSV to RGB, hue on 0..255
    function automatic ctp_pkg::rgb_t convert_hsv(input ctp_pkg::chan_t hue,
                                                  input ctp_pkg::chan_t sat,
                                                  input ctp_pkg::chan_t val);
        int unsigned   h, s, v, sector, frac, lo, fall, rise;
        ctp_pkg::rgb_t c;
        h = hue;
        s = sat;
        v = val;
        if (s == 0)
        begin
            c.red   = val;
            c.green = val;
            c.blue  = val;
            return c;
        end
        sector = h / SectorSpan;
        frac   = (h - sector * SectorSpan) * FracScale;
        lo     = (v * (FullScale - s)) >> 8;
        fall   = (v * (FullScale - ((s * frac) >> 8))) >> 8;
        rise   = (v * (FullScale - ((s * (FullScale - frac)) >> 8))) >> 8;
        case (sector)
            0:       c = {val, 8'(rise), 8'(lo)};
            1:       c = {8'(fall), val, 8'(lo)};
            2:       c = {8'(lo), val, 8'(rise)};
            3:       c = {8'(lo), 8'(fall), val};
            4:       c = {8'(rise), 8'(lo), val};
            default: c = {val, 8'(lo), 8'(fall)};
        endcase
        return c;
    endfunction

    function automatic int unsigned cube_step(input int unsigned x);
        return (x <= DarkLimit) ? 0 : (x - StepBias) / StepWidth;
    endfunction

    // Cube index, or grey ramp when all three steps agree
    function automatic ctp_pkg::chan_t xterm_index(input ctp_pkg::rgb_t c);
        int unsigned r, g, b, sr, sg, sb, shade;
        r  = c.red;
        g  = c.green;
        b  = c.blue;
        sr = cube_step(r);
        sg = cube_step(g);
        sb = cube_step(b);
        if (sr == sg && sg == sb)
        begin
            shade = ((r + g + b) * ShadeMul) / ShadeDiv;
            if (shade == 0)
                return 8'(IndexBase);
            if (shade == ShadeTop)
                return 8'(IndexTop);
            return 8'(IndexTop + shade);
        end
        return 8'(IndexBase + sb + sg * 6 + sr * 36);
    endfunction

    function automatic ctp_pkg::result_t predict_colour(input ctp_pkg::pixel_t px);
        ctp_pkg::rgb_t    c;
        ctp_pkg::result_t res;
        if (px.opcode == ctp_pkg::OP_HSV)
            c = convert_hsv(px.chan_first, px.chan_second, px.chan_third);
        else
            c = {px.chan_first, px.chan_second, px.chan_third};
        res.palette_index = xterm_index(c);
        res.red_out       = c.red;
        res.green_out     = c.green;
        res.blue_out      = c.blue;
        return res;
    endfunction

    function automatic void add_row(input ctp_pkg::opcode_t op, input int a, input int b,
                                    input int c, input bit typed, input int idx,
                                    input int r, input int g, input int bl);
        stim_row_t row;
        row.px.opcode           = op;
        row.px.chan_first       = 8'(a);
        row.px.chan_second      = 8'(b);
        row.px.chan_third       = 8'(c);
        row.typed               = typed;
        row.want.palette_index  = 8'(idx);
        row.want.red_out        = 8'(r);
        row.want.green_out      = 8'(g);
        row.want.blue_out       = 8'(bl);
        directed_rows.push_back(row);
    endfunction

    // Channel value near a level or sector boundary, or at an end
    function automatic ctp_pkg::chan_t edge_chan();
        case ($urandom_range(0, 15))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd42;
            3:       return 8'd43;
            4:       return 8'd75;
            5:       return 8'd76;
            6:       return 8'd115;
            7:       return 8'd116;
            8:       return 8'd155;
            9:       return 8'd156;
            10:      return 8'd195;
            11:      return 8'd196;
            12:      return 8'd235;
            13:      return 8'd236;
            14:      return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic ctp_pkg::chan_t pick_chan();
        return ($urandom_range(0, 3) == 0) ? edge_chan() : 8'($urandom_range(0, 255));
    endfunction

    function automatic ctp_pkg::chan_t jitter_chan(input int base);
        int v;
        v = base + $urandom_range(0, 40) - 20;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic ctp_pkg::pixel_t random_pixel();
        ctp_pkg::pixel_t px;
        int              base;
        int              kind;
        kind           = $urandom_range(0, 9);
        px.chan_first  = pick_chan();
        px.chan_second = pick_chan();
        px.chan_third  = pick_chan();
        px.opcode      = (kind < 5) ? ctp_pkg::OP_HSV : ctp_pkg::OP_RGB;
        // Zero saturation, or hue on or just below a sector boundary
        if (kind == 4)
        begin
            if ($urandom_range(0, 1) == 0)
                px.chan_second = 8'd0;
            else
                px.chan_first = 8'(SectorSpan * $urandom_range(1, 5) - $urandom_range(0, 1));
        end
        // Nearly equal channels to land on the grey ramp
        if (kind == 7 || kind == 8)
        begin
            base           = $urandom_range(0, 255);
            px.chan_first  = jitter_chan(base);
            px.chan_second = jitter_chan(base);
            px.chan_third  = jitter_chan(base);
        end
        return px;
    endfunction

    // Hold the request line low between bursts
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                pixel_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one request and hold it until accepted
    task automatic offer_pixel(input ctp_pkg::pixel_t px, input ctp_pkg::result_t want);
        pixel       <= px;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pending_colours.push_back(want);
    endtask

    // Result side back-pressure, switching pattern now and then
    stall_mode_t stall_mode  = STALL_NONE;
    int unsigned mode_left   = 0;
    logic [3:0]  stall_phase = '0;

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = (stall_mode == STALL_HEAVY) ? $urandom_range(4, 40)
                                                         : $urandom_range(16, 200);
            end
            mode_left--;
            stall_phase <= stall_phase + 1'b1;
            case (stall_mode)
                STALL_NONE:   result_stall <= 1'b0;
                STALL_LIGHT:  result_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY:  result_stall <= ($urandom_range(0, 3) != 0);
                default:      result_stall <= stall_phase[2];
            endcase
        end
    end

    function automatic void check_field(input string name, input ctp_pkg::chan_t want,
                                        input ctp_pkg::chan_t got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= ReportCap)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare each accepted result with the oldest outstanding one
    always @(posedge clk)
    begin : check_results
        ctp_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_colours.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= ReportCap)
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
                             $time, result.palette_index, result.red_out,
                             result.green_out, result.blue_out);
            end
            else
            begin
                want = pending_colours.pop_front();
                check_field("palette_index", want.palette_index, result.palette_index);
                check_field("red_out", want.red_out, result.red_out);
                check_field("green_out", want.green_out, result.green_out);
                check_field("blue_out", want.blue_out, result.blue_out);
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t        row;
        ctp_pkg::result_t want;
        ctp_pkg::pixel_t  px;

        // Ends of each channel, primaries, grey ramp ends and level edges
        add_row(ctp_pkg::OP_RGB, 0, 0, 0, 1, 16, 0, 0, 0);
        add_row(ctp_pkg::OP_RGB, 255, 255, 255, 1, 231, 255, 255, 255);
        add_row(ctp_pkg::OP_RGB, 255, 0, 0, 1, 196, 255, 0, 0);
        add_row(ctp_pkg::OP_RGB, 0, 255, 0, 1, 46, 0, 255, 0);
        add_row(ctp_pkg::OP_RGB, 0, 0, 255, 1, 21, 0, 0, 255);
        add_row(ctp_pkg::OP_RGB, 10, 10, 10, 1, 232, 10, 10, 10);
        add_row(ctp_pkg::OP_RGB, 240, 240, 240, 1, 255, 240, 240, 240);
        add_row(ctp_pkg::OP_RGB, 75, 76, 0, 1, 22, 75, 76, 0);
        add_row(ctp_pkg::OP_RGB, 100, 110, 90, 0, 0, 0, 0, 0);
        // Zero saturation gives grey at the value; then zero value and pure red
        add_row(ctp_pkg::OP_HSV, 0, 0, 200, 1, 251, 200, 200, 200);
        add_row(ctp_pkg::OP_HSV, 255, 0, 255, 1, 231, 255, 255, 255);
        add_row(ctp_pkg::OP_HSV, 123, 45, 0, 1, 16, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 0, 255, 255, 1, 196, 255, 0, 0);
        // Top of the hue range sits in the last sector
        add_row(ctp_pkg::OP_HSV, 255, 255, 255, 1, 196, 255, 0, 15);
        add_row(ctp_pkg::OP_HSV, 214, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 215, 255, 255, 0, 0, 0, 0, 0);
        // Either side of the other four sector boundaries, and one mid-range pixel
        add_row(ctp_pkg::OP_HSV, 42, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 43, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 85, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 86, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 128, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 129, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 171, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 172, 255, 255, 0, 0, 0, 0, 0);
        add_row(ctp_pkg::OP_HSV, 100, 128, 180, 0, 0, 0, 0, 0);

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row  = directed_rows[i];
            want = row.typed ? row.want : predict_colour(row.px);
            pace_sender();
            offer_pixel(row.px, want);
        end

        repeat (RandomPixels)
        begin
            px = random_pixel();
            pace_sender();
            offer_pixel(px, predict_colour(px));
        end
        pixel_valid <= 1'b0;

        // Drain, then allow the pipeline to show any stray result
        while (pending_colours.size() != 0)
            @(posedge clk);
        repeat (ResultLatency + 5) @(posedge clk);

        if (mismatch_count == 0 && pending_colours.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* color_to_terminal_palette.f */
+incdir+rtl/core
rtl/core/ctp_pkg.sv
rtl/core/ctp_hsv.sv
rtl/core/color_to_terminal_palette.sv
tb/sv/testbench.sv
